// File: rtl/core/hs_pkg.sv
// hs_pkg: shared types, sizes and microcode table of the heap sorter
// holds item/result structs, control word and flag structs, the step program
// no dependencies
package hs_pkg;

  localparam int DEPTH = 64;
  localparam int DATAW = 32;
  localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int PCW   = 5;

  typedef logic [IDXW-1:0] idx_t;
  typedef logic [CNTW-1:0] cnt_t;

  typedef struct packed {
    logic signed [DATAW-1:0] value;
    logic                    is_final;
  } item_t;

  typedef struct packed {
    logic signed [DATAW-1:0] sorted_value;
    logic                    end_of_run;
  } result_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PARENT,
    RD_BND,
    RD_ZERO,
    RD_LEFT,
    RD_RIGHT,
    RD_NODE
  } rd_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_UP_ADDR,
    OP_UP_MOVE,
    OP_UP_PLACE,
    OP_BND_INIT,
    OP_TAKE_LAST,
    OP_ROOT_DOWN,
    OP_LEFT,
    OP_PICK_L,
    OP_PICK_R,
    OP_DOWN_MOVE,
    OP_DOWN_PLACE,
    OP_EM_INIT,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACC,
    C_FULL,
    C_NODE_ZERO,
    C_UP_GT,
    C_NO_SORT,
    C_BND_ZERO,
    C_NO_LEFT,
    C_NO_RIGHT,
    C_DN_GT,
    C_BUSY,
    C_MORE
  } cond_t;

  typedef enum logic [PCW-1:0] {
    S_IDLE,
    S_FULL,
    S_UP_TEST,
    S_UP_CMP,
    S_UP_END,
    S_CHKFIN,
    S_SORT_INIT,
    S_SL_TEST,
    S_SL_RDB,
    S_SL_SWAP,
    S_SD_TEST,
    S_SD_RDL,
    S_SD_RDR,
    S_SD_CMP,
    S_SD_END,
    S_EM_INIT,
    S_EM_RD,
    S_EM_WR,
    S_EM_NEXT,
    S_EM_DONE
  } step_t;

  typedef struct packed {
    logic    in_rdy;
    rd_sel_t rd;
    op_t     op;
    cond_t   cond;
    step_t   target;
  } ctrl_t;

  typedef struct packed {
    logic acc;
    logic full;
    logic node_zero;
    logic up_gt;
    logic no_sort;
    logic bnd_zero;
    logic no_left;
    logic no_right;
    logic dn_gt;
    logic busy;
    logic more;
  } flags_t;

  function automatic ctrl_t cw(logic in_rdy, rd_sel_t rd, op_t op, cond_t cond,
                               step_t target);
    ctrl_t c;
    c.in_rdy = in_rdy;
    c.rd     = rd;
    c.op     = op;
    c.cond   = cond;
    c.target = target;
    return c;
  endfunction

  // step program: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    unique case (s)
      S_IDLE:      c = cw(1'b1, RD_NONE,   OP_LOAD,       C_NO_ACC,    S_IDLE);
      S_FULL:      c = cw(1'b0, RD_NONE,   OP_NONE,       C_FULL,      S_CHKFIN);
      S_UP_TEST:   c = cw(1'b0, RD_PARENT, OP_UP_ADDR,    C_NODE_ZERO, S_UP_END);
      S_UP_CMP:    c = cw(1'b0, RD_NONE,   OP_UP_MOVE,    C_UP_GT,     S_UP_TEST);
      S_UP_END:    c = cw(1'b0, RD_NONE,   OP_UP_PLACE,   C_NEVER,     S_IDLE);
      S_CHKFIN:    c = cw(1'b0, RD_NONE,   OP_NONE,       C_NO_SORT,   S_IDLE);
      S_SORT_INIT: c = cw(1'b0, RD_NONE,   OP_BND_INIT,   C_NEVER,     S_IDLE);
      S_SL_TEST:   c = cw(1'b0, RD_BND,    OP_NONE,       C_BND_ZERO,  S_EM_INIT);
      S_SL_RDB:    c = cw(1'b0, RD_ZERO,   OP_TAKE_LAST,  C_NEVER,     S_IDLE);
      S_SL_SWAP:   c = cw(1'b0, RD_NONE,   OP_ROOT_DOWN,  C_NEVER,     S_IDLE);
      S_SD_TEST:   c = cw(1'b0, RD_LEFT,   OP_LEFT,       C_NO_LEFT,   S_SD_END);
      S_SD_RDL:    c = cw(1'b0, RD_RIGHT,  OP_PICK_L,     C_NO_RIGHT,  S_SD_CMP);
      S_SD_RDR:    c = cw(1'b0, RD_NONE,   OP_PICK_R,     C_NEVER,     S_IDLE);
      S_SD_CMP:    c = cw(1'b0, RD_NONE,   OP_DOWN_MOVE,  C_DN_GT,     S_SD_TEST);
      S_SD_END:    c = cw(1'b0, RD_NONE,   OP_DOWN_PLACE, C_ALWAYS,    S_SL_TEST);
      S_EM_INIT:   c = cw(1'b0, RD_NONE,   OP_EM_INIT,    C_NEVER,     S_IDLE);
      S_EM_RD:     c = cw(1'b0, RD_NODE,   OP_NONE,       C_NEVER,     S_IDLE);
      S_EM_WR:     c = cw(1'b0, RD_NONE,   OP_EMIT,       C_BUSY,      S_EM_WR);
      S_EM_NEXT:   c = cw(1'b0, RD_NONE,   OP_NONE,       C_MORE,      S_EM_RD);
      S_EM_DONE:   c = cw(1'b0, RD_NONE,   OP_NONE,       C_ALWAYS,    S_IDLE);
      default:     c = cw(1'b0, RD_NONE,   OP_NONE,       C_ALWAYS,    S_IDLE);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/hs_sequencer.sv
// hs_sequencer: step counter, microcode table lookup and conditional jumps
// depends on hs_pkg for the control word, flags and program
module hs_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  hs_pkg::flags_t flags,
  output hs_pkg::ctrl_t  ctrl
);

  hs_pkg::step_t pc;
  hs_pkg::step_t pc_next;
  logic          take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= hs_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    ctrl = hs_pkg::ucode(pc);
  end

  always_comb begin
    unique case (ctrl.cond)
      hs_pkg::C_NEVER:     take = 1'b0;
      hs_pkg::C_ALWAYS:    take = 1'b1;
      hs_pkg::C_NO_ACC:    take = !flags.acc;
      hs_pkg::C_FULL:      take = flags.full;
      hs_pkg::C_NODE_ZERO: take = flags.node_zero;
      hs_pkg::C_UP_GT:     take = flags.up_gt;
      hs_pkg::C_NO_SORT:   take = flags.no_sort;
      hs_pkg::C_BND_ZERO:  take = flags.bnd_zero;
      hs_pkg::C_NO_LEFT:   take = flags.no_left;
      hs_pkg::C_NO_RIGHT:  take = flags.no_right;
      hs_pkg::C_DN_GT:     take = flags.dn_gt;
      hs_pkg::C_BUSY:      take = flags.busy;
      hs_pkg::C_MORE:      take = flags.more;
      default:             take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : hs_pkg::step_t'(pc + 1'b1);
  end

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= hs_pkg::S_EM_DONE)
    else $error("step counter left the program");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    flags.acc |=> (pc == hs_pkg::S_FULL))
    else $error("transfer did not start the insert sequence");

  a_emit_after_sort: assert property (@(posedge clk) disable iff (rst)
    (pc == hs_pkg::S_EM_INIT) |-> ($past(pc) == hs_pkg::S_SL_TEST))
    else $error("emit entered without the sort loop ending");

endmodule

// File: rtl/core/hs_datapath.sv
// hs_datapath: heap store, index and value registers, compare flags, result register
// depends on hs_pkg; driven by the control word from hs_sequencer
module hs_datapath (
  input  logic            clk,
  input  logic            rst,
  input  hs_pkg::ctrl_t   ctrl,
  output hs_pkg::flags_t  flags,
  input  logic            item_valid,
  input  hs_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_stall,
  output hs_pkg::result_t result
);

  logic signed [hs_pkg::DATAW-1:0] mem [hs_pkg::DEPTH];
  logic signed [hs_pkg::DATAW-1:0] q;
  logic signed [hs_pkg::DATAW-1:0] cval;
  logic signed [hs_pkg::DATAW-1:0] pval;
  logic signed [hs_pkg::DATAW-1:0] wr_data;
  hs_pkg::cnt_t                    cnt;
  hs_pkg::idx_t                    bnd;
  hs_pkg::idx_t                    node;
  hs_pkg::idx_t                    idx2;
  logic                            fin;
  logic                            result_valid_next;

  hs_pkg::idx_t      rd_addr;
  hs_pkg::idx_t      wr_addr;
  hs_pkg::idx_t      parent;
  logic              rd_en;
  logic              wr_en;
  logic [hs_pkg::IDXW:0] left;
  logic [hs_pkg::IDXW:0] right;
  logic [hs_pkg::IDXW:0] bnd_x;
  logic              last_emit;
  logic              load_out;

  assign parent    = hs_pkg::idx_t'((node - 1'b1) >> 1);
  assign left      = {node, 1'b1};
  assign right     = {1'b0, idx2} + 1'b1;
  assign bnd_x     = {1'b0, bnd};
  assign last_emit = (hs_pkg::cnt_t'(node) == cnt - 1'b1);

  always_comb begin
    flags.acc       = item_valid && ctrl.in_rdy;
    flags.full      = (cnt == hs_pkg::cnt_t'(hs_pkg::DEPTH));
    flags.node_zero = (node == '0);
    flags.up_gt     = (cval > q);
    flags.no_sort   = !fin || (cnt == '0);
    flags.bnd_zero  = (bnd == '0);
    flags.no_left   = (left > bnd_x);
    flags.no_right  = (right > bnd_x);
    flags.dn_gt     = (pval > cval);
    flags.busy      = result_valid && result_stall;
    flags.more      = !result.end_of_run;
  end

  assign load_out = (ctrl.op == hs_pkg::OP_EMIT) && !flags.busy;

  always_comb begin
    unique case (ctrl.rd)
      hs_pkg::RD_NONE:   rd_addr = node;
      hs_pkg::RD_PARENT: rd_addr = parent;
      hs_pkg::RD_BND:    rd_addr = bnd;
      hs_pkg::RD_ZERO:   rd_addr = '0;
      hs_pkg::RD_LEFT:   rd_addr = left[hs_pkg::IDXW-1:0];
      hs_pkg::RD_RIGHT:  rd_addr = right[hs_pkg::IDXW-1:0];
      hs_pkg::RD_NODE:   rd_addr = node;
      default:           rd_addr = node;
    endcase
    rd_en = (ctrl.rd != hs_pkg::RD_NONE);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = cval;
    unique case (ctrl.op)
      hs_pkg::OP_UP_MOVE: begin
        wr_en   = flags.up_gt;
        wr_data = q;
      end
      hs_pkg::OP_UP_PLACE: begin
        wr_en = 1'b1;
      end
      hs_pkg::OP_ROOT_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = bnd;
        wr_data = q;
      end
      hs_pkg::OP_DOWN_MOVE: begin
        wr_en   = flags.dn_gt;
        wr_data = pval;
      end
      hs_pkg::OP_DOWN_PLACE: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // heap store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_comb begin
    result_valid_next = result_valid;
    if (load_out) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      bnd          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      unique case (ctrl.op)
        hs_pkg::OP_UP_PLACE: cnt <= cnt + 1'b1;
        hs_pkg::OP_BND_INIT: bnd <= hs_pkg::idx_t'(cnt - 1'b1);
        hs_pkg::OP_ROOT_DOWN: bnd <= bnd - 1'b1;
        hs_pkg::OP_EMIT: begin
          if (load_out && last_emit) begin
            cnt <= '0;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      hs_pkg::OP_LOAD: begin
        if (flags.acc) begin
          cval <= item.value;
          fin  <= item.is_final;
          node <= hs_pkg::idx_t'(cnt);
        end
      end
      hs_pkg::OP_UP_ADDR: idx2 <= parent;
      hs_pkg::OP_UP_MOVE: begin
        if (flags.up_gt) begin
          node <= idx2;
        end
      end
      hs_pkg::OP_TAKE_LAST: cval <= q;
      hs_pkg::OP_ROOT_DOWN: node <= '0;
      hs_pkg::OP_LEFT:      idx2 <= left[hs_pkg::IDXW-1:0];
      hs_pkg::OP_PICK_L:    pval <= q;
      hs_pkg::OP_PICK_R: begin
        // ties go to the right child
        if (!(pval > q)) begin
          pval <= q;
          idx2 <= idx2 + 1'b1;
        end
      end
      hs_pkg::OP_DOWN_MOVE: begin
        if (flags.dn_gt) begin
          node <= idx2;
        end
      end
      hs_pkg::OP_EM_INIT: node <= '0;
      hs_pkg::OP_EMIT: begin
        if (load_out) begin
          result.sorted_value <= q;
          result.end_of_run   <= last_emit;
          node                <= node + 1'b1;
        end
      end
      default: begin
        node <= node;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= hs_pkg::cnt_t'(hs_pkg::DEPTH))
    else $error("element count beyond depth");

  a_down_in_heap: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == hs_pkg::OP_DOWN_MOVE) |-> (node < bnd))
    else $error("sift-down node outside unsorted part");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == hs_pkg::OP_EMIT) |-> (hs_pkg::cnt_t'(node) < cnt))
    else $error("emit index beyond stored batch");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (load_out && last_emit) |=> (cnt == '0) && result.end_of_run)
    else $error("last result did not empty the store");

endmodule

// File: rtl/core/heap_sorter.sv
// heap_sorter: batch heap sorter, microcoded sequencer driving a heap datapath
// depends on hs_pkg, hs_sequencer, hs_datapath
//
//   channel  | signals                              | direction | payload
//   item     | item_valid, item_stall, item         | in        | value, is_final
//   result   | result_valid, result_stall, result   | out       | sorted_value, end_of_run
//
// an item is loaded and sifts up, comparing with its parent at each level it rises
// a final item then runs the sort: per entry the root swaps to the heap end and the last
// entry sifts down through the store's single read port, then each result is emitted
// reset clears step counter, element count, sift bound and result valid; store undefined
// result stall holds the emit step; items are taken only while the sequencer is idle
module heap_sorter (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  hs_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_stall,
  output hs_pkg::result_t result
);

  hs_pkg::ctrl_t  ctrl;
  hs_pkg::flags_t flags;

  assign item_stall = !ctrl.in_rdy;

  hs_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  hs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .flags        (flags),
    .item_valid   (item_valid),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
